>>> rtl/aepm_pkg.sv
// Shared types, constants and helpers for the adverse excursion marker block.
`default_nettype none
package aepm_pkg;
  localparam int MAX_TRADES = 256;
  localparam int CNT_W = $clog2(MAX_TRADES + 1);
  localparam int IDX_W = $clog2(MAX_TRADES);
  localparam int VAL_W = 39;
  localparam int MRK_W = 40;
  localparam int FRAC_W = 17;
  localparam int POS_W = FRAC_W + CNT_W;
  localparam logic [FRAC_W-1:0] FRAC_ONE = FRAC_W'(65536);
  localparam logic [FRAC_W-1:0] GREEN_RST = FRAC_W'(32768);
  localparam logic [FRAC_W-1:0] YELLOW_RST = FRAC_W'(49152);
  localparam logic [FRAC_W-1:0] RED_RST = FRAC_W'(55706);

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_STATS = 2'd1,
    OP_BAR   = 2'd2,
    OP_CLEAR = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    REG_GREEN  = 2'd0,
    REG_YELLOW = 2'd1,
    REG_RED    = 2'd2,
    REG_PPC    = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    DIR_FLAT  = 2'd0,
    DIR_LONG  = 2'd1,
    DIR_SHORT = 2'd2
  } dir_t;

  // control shared by every cell of the row
  typedef struct packed {
    logic             insert;
    logic             rotate;
    logic [VAL_W-1:0] key;
  } cell_ctl_t;

  function automatic logic [MRK_W-1:0] sat40(input logic signed [57:0] v);
    logic signed [57:0] hi;
    logic signed [57:0] lo;
    hi = 58'sd549755813887;
    lo = -58'sd549755813888;
    if (v > hi) begin
      sat40 = hi[MRK_W-1:0];
    end else if (v < lo) begin
      sat40 = lo[MRK_W-1:0];
    end else begin
      sat40 = v[MRK_W-1:0];
    end
  endfunction
endpackage
`default_nettype wire

>>> rtl/adverse_excursion_percentile_markers.sv
// Top level: op sequencer, percentile scan, position tracking and markers.
// Load and clear pass through S_LOAD or S_CLR to the result strobe in S_EMIT; bar through S_BAR1 and S_BAR2.
// Compute: S_CSET, one full rotation of the cell row in S_CSCAN, then S_CMUL, S_CADD and S_EMIT.
// busy stays high through the result cycle, so a new start is taken in the cycle after it at the earliest.
// Sync reset clears count, levels, direction, prices and registers; store contents stay.
`default_nettype none
module adverse_excursion_percentile_markers (
  input  wire                         clk,
  input  wire                         rst,
  input  wire                         start,
  output logic                        busy,
  output logic                        done,
  input  wire [1:0]                   op,
  input  wire signed [39:0]           trade_profit,
  input  wire signed [39:0]           trade_adverse,
  input  wire signed [15:0]           position_qty,
  input  wire [38:0]                  average_price,
  input  wire [38:0]                  bar_low,
  input  wire [38:0]                  bar_high,
  input  wire                         cfg_valid,
  output logic                        cfg_ready,
  input  wire [1:0]                   cfg_index,
  input  wire [31:0]                  cfg_data,
  output logic signed [39:0]          yellow_long,
  output logic signed [39:0]          red_long,
  output logic signed [39:0]          yellow_short,
  output logic signed [39:0]          red_short,
  output logic [38:0]                 worst_seen,
  output logic [38:0]                 green_stat,
  output logic [38:0]                 yellow_stat,
  output logic [38:0]                 red_stat,
  output logic                        dropped
);
  import aepm_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_LOAD  = 10'b0000000010,
    S_CLR   = 10'b0000000100,
    S_BAR1  = 10'b0000001000,
    S_BAR2  = 10'b0000010000,
    S_CSET  = 10'b0000100000,
    S_CSCAN = 10'b0001000000,
    S_CMUL  = 10'b0010000000,
    S_CADD  = 10'b0100000000,
    S_EMIT  = 10'b1000000000
  } state_t;

  state_t state, state_next;

  logic [FRAC_W-1:0] frac [3];
  logic [31:0]       ppc;
  logic [CNT_W-1:0]  count;
  logic [VAL_W-1:0]  level [3];
  dir_t              dir;
  logic [VAL_W-1:0]  entry;
  logic [VAL_W-1:0]  worst;

  logic signed [39:0] in_profit;
  logic signed [39:0] in_adverse;
  logic [15:0]        in_qty;
  logic [VAL_W-1:0]   in_avg;
  logic [VAL_W-1:0]   in_lo;
  logic [VAL_W-1:0]   in_hi;

  logic [IDX_W-1:0]   lo_idx [3];
  logic [15:0]        f_part [3];
  logic [VAL_W-1:0]   base_v [3];
  logic [VAL_W-1:0]   nxt_v  [3];
  logic [54:0]        prod   [3];
  logic [IDX_W-1:0]   k;

  logic [54:0]        p_gh, p_gl, p_rh, p_rl;
  logic [MRK_W-1:0]   mark [4];
  logic               drop_r;

  cell_ctl_t          ctl;
  logic [VAL_W-1:0]   head;
  logic               accept;
  logic [39:0]        mag40;
  logic [VAL_W-1:0]   mag;
  logic               keep;

  assign accept    = start && !busy;
  assign busy      = (state != S_IDLE);
  assign done      = (state == S_EMIT);
  assign cfg_ready = 1'b1;

  assign mag40 = in_adverse[39] ? 40'(-in_adverse) : 40'(in_adverse);
  assign mag   = mag40[39] ? {VAL_W{1'b1}} : mag40[VAL_W-1:0];
  assign keep  = !in_profit[39] && (in_profit != '0) && (mag != '0);

  assign ctl.insert = (state == S_LOAD) && keep && (count < CNT_W'(MAX_TRADES));
  assign ctl.rotate = (state == S_CSCAN);
  assign ctl.key    = mag;

  aepm_chain u_chain (
    .clk   (clk),
    .ctl   (ctl),
    .count (count),
    .head  (head)
  );

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (op_t'(op))
            OP_LOAD:  state_next = S_LOAD;
            OP_STATS: state_next = S_CSET;
            OP_BAR:   state_next = S_BAR1;
            OP_CLEAR: state_next = S_CLR;
            default:  state_next = S_IDLE;
          endcase
        end
      end
      S_LOAD:  state_next = S_EMIT;
      S_CLR:   state_next = S_EMIT;
      S_BAR1:  state_next = S_BAR2;
      S_BAR2:  state_next = S_EMIT;
      S_CSET:  state_next = S_CSCAN;
      S_CSCAN: state_next = (k == IDX_W'(MAX_TRADES - 1)) ? S_CMUL : S_CSCAN;
      S_CMUL:  state_next = S_CADD;
      S_CADD:  state_next = S_EMIT;
      S_EMIT:  state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      frac[0] <= GREEN_RST;
      frac[1] <= YELLOW_RST;
      frac[2] <= RED_RST;
      ppc     <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (reg_idx_t'(cfg_index))
        REG_GREEN:  frac[0] <= cfg_data[FRAC_W-1:0];
        REG_YELLOW: frac[1] <= cfg_data[FRAC_W-1:0];
        REG_RED:    frac[2] <= cfg_data[FRAC_W-1:0];
        REG_PPC:    ppc     <= cfg_data;
        default: ;
      endcase
    end
  end

  // input word capture
  always_ff @(posedge clk) begin
    if (accept) begin
      in_profit  <= trade_profit;
      in_adverse <= trade_adverse;
      in_qty     <= position_qty;
      in_avg     <= average_price;
      in_lo      <= bar_low;
      in_hi      <= bar_high;
    end
  end

  // store count and drop flag
  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= '0;
      drop_r <= 1'b0;
    end else begin
      if (accept) begin
        drop_r <= 1'b0;
      end
      if (state == S_LOAD && keep) begin
        if (count < CNT_W'(MAX_TRADES)) begin
          count <= count + 1'b1;
        end else begin
          drop_r <= 1'b1;
        end
      end
      if (state == S_CLR) begin
        count <= '0;
      end
    end
  end

  // percentile: positions, then one rotation of the row picking out neighbours
  always_ff @(posedge clk) begin
    logic [FRAC_W-1:0] p;
    logic [POS_W-1:0]  pos;
    if (state == S_CSET) begin
      k <= '0;
      for (int j = 0; j < 3; j++) begin
        p   = (frac[j] > FRAC_ONE) ? FRAC_ONE : frac[j];
        pos = POS_W'(p) * POS_W'(count - CNT_W'(1));
        lo_idx[j] <= pos[16 +: IDX_W];
        f_part[j] <= pos[15:0];
      end
    end
    if (state == S_CSCAN) begin
      k <= k + 1'b1;
      for (int j = 0; j < 3; j++) begin
        if (k == lo_idx[j]) begin
          base_v[j] <= head;
        end
        if ({1'b0, k} == {1'b0, lo_idx[j]} + (IDX_W + 1)'(1)) begin
          nxt_v[j] <= head;
        end
      end
    end
    if (state == S_CMUL) begin
      for (int j = 0; j < 3; j++) begin
        prod[j] <= 55'(nxt_v[j] - base_v[j]) * 55'(f_part[j]);
      end
    end
  end

  always_ff @(posedge clk) begin
    logic [54:0] r;
    if (rst) begin
      for (int j = 0; j < 3; j++) begin
        level[j] <= '0;
      end
    end else if (state == S_CADD) begin
      for (int j = 0; j < 3; j++) begin
        r = prod[j] + 55'h8000;
        if (count == '0) begin
          level[j] <= '0;
        end else if (f_part[j] == '0) begin
          level[j] <= base_v[j];
        end else begin
          level[j] <= base_v[j] + r[16 +: VAL_W];
        end
      end
    end
  end

  // position tracking and marker offsets
  always_ff @(posedge clk) begin
    dir_t nd;
    if (rst) begin
      dir   <= DIR_FLAT;
      entry <= '0;
      worst <= '0;
    end else if (state == S_BAR1) begin
      if (in_qty == '0) begin
        dir <= DIR_FLAT;
      end else begin
        nd = in_qty[15] ? DIR_SHORT : DIR_LONG;
        dir <= nd;
        if (dir != nd) begin
          entry <= in_avg;
          worst <= (nd == DIR_LONG) ? in_lo : in_hi;
        end else if (nd == DIR_LONG) begin
          if (in_lo < worst) worst <= in_lo;
        end else begin
          if (in_hi > worst) worst <= in_hi;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_BAR1) begin
      p_gh <= 55'(level[0]) * 55'(ppc[31:16]);
      p_gl <= 55'(level[0]) * 55'(ppc[15:0]);
      p_rh <= 55'(level[2]) * 55'(ppc[31:16]);
      p_rl <= 55'(level[2]) * 55'(ppc[15:0]);
    end
  end

  always_ff @(posedge clk) begin
    logic [55:0]        og;
    logic [55:0]        orr;
    logic [54:0]        tg;
    logic [54:0]        tr;
    logic signed [57:0] e;
    if (accept) begin
      for (int j = 0; j < 4; j++) begin
        mark[j] <= '0;
      end
    end else if (state == S_BAR2) begin
      tg  = p_gl + 55'h8000;
      tr  = p_rl + 55'h8000;
      og  = 56'(p_gh) + 56'(tg[54:16]);
      orr = 56'(p_rh) + 56'(tr[54:16]);
      e   = 58'(entry);
      if (in_qty != '0 && ppc != '0) begin
        if (level[0] != '0) begin
          if (dir == DIR_LONG) mark[0] <= sat40(e - 58'(og));
          else                 mark[2] <= sat40(e + 58'(og));
        end
        if (level[2] != '0) begin
          if (dir == DIR_LONG) mark[1] <= sat40(e - 58'(orr));
          else                 mark[3] <= sat40(e + 58'(orr));
        end
      end
    end
  end

  assign yellow_long  = mark[0];
  assign red_long     = mark[1];
  assign yellow_short = mark[2];
  assign red_short    = mark[3];
  assign worst_seen   = (dir == DIR_FLAT) ? '0 : worst;
  assign green_stat   = level[0];
  assign yellow_stat  = level[1];
  assign red_stat     = level[2];
  assign dropped      = drop_r;
endmodule
`default_nettype wire

>>> rtl/aepm_cell.sv
// One sorted-store cell: ordered insert from the left, rotation from the right.
`default_nettype none
module aepm_cell (
  input  wire                        clk,
  input  aepm_pkg::cell_ctl_t        ctl,
  input  wire                        valid_self,
  input  wire                        left_gt,
  input  wire [aepm_pkg::VAL_W-1:0]  left_val,
  input  wire [aepm_pkg::VAL_W-1:0]  right_val,
  output logic [aepm_pkg::VAL_W-1:0] val,
  output logic                       gt
);
  import aepm_pkg::*;

  logic [VAL_W-1:0] val_next;

  assign gt = valid_self && (val > ctl.key);

  always_comb begin
    val_next = val;
    if (ctl.rotate) begin
      val_next = right_val;
    end else if (ctl.insert) begin
      if (left_gt) begin
        val_next = left_val;
      end else if (gt || !valid_self) begin
        val_next = ctl.key;
      end
    end
  end

  always_ff @(posedge clk) begin
    val <= val_next;
  end
endmodule
`default_nettype wire

>>> rtl/aepm_chain.sv
// Row of cells holding the kept magnitudes in ascending order.
`default_nettype none
module aepm_chain (
  input  wire                        clk,
  input  aepm_pkg::cell_ctl_t        ctl,
  input  wire [aepm_pkg::CNT_W-1:0]  count,
  output logic [aepm_pkg::VAL_W-1:0] head
);
  import aepm_pkg::*;

  logic [VAL_W-1:0] vals [MAX_TRADES];
  logic             gts  [MAX_TRADES];

  genvar i;
  generate
    for (i = 0; i < MAX_TRADES; i++) begin : g_cell
      logic             lgt;
      logic [VAL_W-1:0] lval;
      logic [VAL_W-1:0] rval;
      if (i == 0) begin : g_first
        assign lgt  = 1'b0;
        assign lval = ctl.key;
      end else begin : g_rest
        assign lgt  = gts[i-1];
        assign lval = vals[i-1];
      end
      assign rval = vals[(i + 1) % MAX_TRADES];
      aepm_cell u_cell (
        .clk        (clk),
        .ctl        (ctl),
        .valid_self (CNT_W'(i) < count),
        .left_gt    (lgt),
        .left_val   (lval),
        .right_val  (rval),
        .val        (vals[i]),
        .gt         (gts[i])
      );
    end
  endgenerate

  assign head = vals[0];
endmodule
`default_nettype wire

>>> rtl/aepm_checker.sv
// Port-level checks on the command handshake, result strobe and drop flag.
`default_nettype none
module aepm_checker (
  input wire clk,
  input wire rst,
  input wire start,
  input wire busy,
  input wire done,
  input wire dropped
);
  a_done_busy: assert property (@(posedge clk) disable iff (rst) done |-> busy)
    else $error("result strobe outside busy");
  a_done_single: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("two result strobes back to back");
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy && !done))
    else $error("accepted word did not raise busy");
  a_done_ends: assert property (@(posedge clk) disable iff (rst) done |=> !busy)
    else $error("busy held after result");
  a_drop_busy: assert property (@(posedge clk) disable iff (rst)
    (dropped && !busy) |=> (dropped || busy))
    else $error("drop flag changed while idle");
endmodule

bind adverse_excursion_percentile_markers aepm_checker u_aepm_checker (
  .clk     (clk),
  .rst     (rst),
  .start   (start),
  .busy    (busy),
  .done    (done),
  .dropped (dropped)
);
`default_nettype wire

>>> test/tb_adverse_excursion_percentile_markers.sv
// Testbench for the adverse excursion percentile marker block: scoreboard and drivers.
`default_nettype none
module tb_adverse_excursion_percentile_markers;
  import aepm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    op_t                op;
    logic signed [39:0] profit;
    logic signed [39:0] adverse;
    logic signed [15:0] qty;
    logic [38:0]        avg;
    logic [38:0]        lo;
    logic [38:0]        hi;
  } trade_word_t;

  typedef struct {
    logic [39:0] yl, rl, ys, rs;
    logic [38:0] worst, gs, ysat, rsat;
    logic        drop;
  } marker_word_t;

  class marker_scoreboard;
    logic [38:0]  store[MAX_TRADES];
    int unsigned  count;
    logic [38:0]  green, yellow, red;
    dir_t         dir;
    logic [38:0]  entry, worst;
    logic [16:0]  gfrac, yfrac, rfrac;
    logic [31:0]  ppc;
    marker_word_t pending[$];
    int           errors;

    function new();
      count = 0; green = 0; yellow = 0; red = 0; dir = DIR_FLAT;
      entry = 0; worst = 0; gfrac = GREEN_RST; yfrac = YELLOW_RST; rfrac = RED_RST;
      ppc = 0; errors = 0;
    endfunction

    function void write_reg(reg_idx_t idx, logic [31:0] d);
      case (idx)
        REG_GREEN:  gfrac = d[16:0];
        REG_YELLOW: yfrac = d[16:0];
        REG_RED:    rfrac = d[16:0];
        REG_PPC:    ppc = d;
        default: ;
      endcase
    endfunction

    function logic [38:0] interp(logic [16:0] frac);
      longint unsigned p, pos, lo, f, base, diff;
      p = (frac > FRAC_ONE) ? FRAC_ONE : frac;
      if (count == 0) return 0;
      if (count == 1) return store[0];
      pos = p * (count - 1);
      lo = pos >> 16;
      f = pos & 16'hFFFF;
      if (lo >= count) lo = count - 1;
      base = store[lo];
      if (f == 0 || lo + 1 >= count) return base;
      diff = store[lo+1] - base;
      return 39'(base + ((diff * f + 32'h8000) >> 16));
    endfunction

    function longint signed offset(logic [38:0] level);
      longint unsigned lv;
      lv = level;
      return lv * ppc[31:16] + ((lv * ppc[15:0] + 32'h8000) >> 16);
    endfunction

    function logic [39:0] clip40(longint signed v);
      if (v > 64'sd549755813887) v = 64'sd549755813887;
      if (v < -64'sd549755813888) v = -64'sd549755813888;
      return v[39:0];
    endfunction

    function void note(trade_word_t w);
      marker_word_t r;
      longint unsigned mag;
      logic [38:0] key;
      dir_t nd;
      int j;
      r = '{default: 0};
      case (w.op)
        OP_LOAD: if (w.profit > 0) begin
          mag = (w.adverse < 0) ? -longint'(w.adverse) : longint'(w.adverse);
          if (mag > 39'h7F_FFFF_FFFF) mag = 39'h7F_FFFF_FFFF;
          if (mag != 0) begin
            if (count >= MAX_TRADES) r.drop = 1;
            else begin store[count] = mag[38:0]; count++; end
          end
        end
        OP_STATS: begin
          for (int i = 1; i < count; i++) begin
            key = store[i];
            j = i;
            while (j > 0 && store[j-1] > key) begin store[j] = store[j-1]; j--; end
            store[j] = key;
          end
          green = interp(gfrac);
          yellow = interp(yfrac);
          red = interp(rfrac);
        end
        OP_CLEAR: count = 0;
        default: begin
          if (w.qty == 0) dir = DIR_FLAT;
          else begin
            nd = w.qty[15] ? DIR_SHORT : DIR_LONG;
            if (dir != nd) begin
              entry = w.avg;
              worst = (nd == DIR_LONG) ? w.lo : w.hi;
            end
            dir = nd;
            if (nd == DIR_LONG && w.lo < worst) worst = w.lo;
            if (nd == DIR_SHORT && w.hi > worst) worst = w.hi;
            if (ppc != 0) begin
              if (green != 0) begin
                if (nd == DIR_LONG) r.yl = clip40(longint'(entry) - offset(green));
                else r.ys = clip40(longint'(entry) + offset(green));
              end
              if (red != 0) begin
                if (nd == DIR_LONG) r.rl = clip40(longint'(entry) - offset(red));
                else r.rs = clip40(longint'(entry) + offset(red));
              end
            end
          end
        end
      endcase
      r.worst = (dir == DIR_FLAT) ? 39'd0 : worst;
      r.gs = green; r.ysat = yellow; r.rsat = red;
      pending = {pending, r};
    endfunction

    function void cmp(string name, logic [39:0] e, logic [39:0] a);
      if (e !== a) begin
        $error("%s: expected %0h, got %0h", name, e, a);
        errors++;
      end
    endfunction

    function void check(marker_word_t a);
      marker_word_t e;
      if (pending.size() == 0) begin
        $error("result word with nothing outstanding");
        errors++;
        return;
      end
      e = pending.pop_front();
      cmp("yellow_long", e.yl, a.yl);
      cmp("red_long", e.rl, a.rl);
      cmp("yellow_short", e.ys, a.ys);
      cmp("red_short", e.rs, a.rs);
      cmp("worst_seen", e.worst, a.worst);
      cmp("green_stat", e.gs, a.gs);
      cmp("yellow_stat", e.ysat, a.ysat);
      cmp("red_stat", e.rsat, a.rsat);
      cmp("dropped", e.drop, a.drop);
    endfunction
  endclass

  logic clk, rst, start, cfg_valid;
  logic [1:0] op, cfg_index;
  logic [31:0] cfg_data;
  logic signed [39:0] trade_profit, trade_adverse;
  logic signed [15:0] position_qty;
  logic [38:0] average_price, bar_low, bar_high;
  wire busy, done, cfg_ready, dropped;
  wire signed [39:0] yellow_long, red_long, yellow_short, red_short;
  wire [38:0] worst_seen, green_stat, yellow_stat, red_stat;

  adverse_excursion_percentile_markers dut (.*);

  marker_scoreboard sb = new();
  int idle_pct;
  int quiet = 0;
  logic long_side;
  logic [38:0] base_price;

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  // any accepted word, in either direction, counts as progress
  always @(posedge clk) begin
    if (!rst && done) begin
      sb.check('{yellow_long, red_long, yellow_short, red_short, worst_seen,
                 green_stat, yellow_stat, red_stat, dropped});
    end
    if ((!rst && done) || (start && !busy) || (cfg_valid && cfg_ready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
    end
    if (quiet > 20000) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic send(trade_word_t w);
    while ($urandom_range(99) < idle_pct) begin
      start <= 0;
      @(negedge clk);
    end
    start <= 1;
    op <= w.op; trade_profit <= w.profit; trade_adverse <= w.adverse;
    position_qty <= w.qty; average_price <= w.avg; bar_low <= w.lo; bar_high <= w.hi;
    do @(posedge clk); while (busy);
    sb.note(w);
    @(negedge clk);
  endtask

  task automatic set_reg(reg_idx_t idx, logic [31:0] d);
    start <= 0;
    cfg_valid <= 1; cfg_index <= idx; cfg_data <= d;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, d);
    @(negedge clk);
    cfg_valid <= 0;
  endtask

  // drain before touching registers
  task automatic settle();
    start <= 0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_all(logic [31:0] g, logic [31:0] y, logic [31:0] r, logic [31:0] p);
    settle();
    set_reg(REG_GREEN, g);
    set_reg(REG_YELLOW, y);
    set_reg(REG_RED, r);
    set_reg(REG_PPC, p);
  endtask

  function automatic logic [63:0] rnd64();
    return {$urandom, $urandom};
  endfunction

  function automatic trade_word_t mk(op_t o, logic signed [39:0] p, logic signed [39:0] a,
                                     logic signed [15:0] q, logic [38:0] av,
                                     logic [38:0] l, logic [38:0] h);
    return '{o, p, a, q, av, l, h};
  endfunction

  function automatic logic [38:0] price();
    if ($urandom_range(9) == 0) return 39'(rnd64());
    return base_price + 39'($urandom_range(65536 * 50)) - 39'(65536 * 25);
  endfunction

  function automatic trade_word_t rand_load();
    trade_word_t w;
    w = mk(OP_LOAD, 40'($urandom_range(65536 * 500, 1)), 0, 16'(rnd64()), 39'(rnd64()),
           39'(rnd64()), 39'(rnd64()));
    if ($urandom_range(9) == 0) w.profit = 40'(rnd64());
    if ($urandom_range(9) == 0) w.adverse = 40'(rnd64());
    else begin
      w.adverse = 40'($urandom_range(65536 * 300));
      if ($urandom_range(1)) w.adverse = -w.adverse;
    end
    return w;
  endfunction

  function automatic trade_word_t rand_word();
    trade_word_t w;
    int k;
    k = $urandom_range(99);
    w = rand_load();
    if (k < 50) return w;
    if (k < 80) begin
      if ($urandom_range(9) == 0) long_side = ~long_side;
      if ($urandom_range(19) == 0) base_price = 39'(rnd64());
      w.op = OP_BAR;
      w.qty = 16'($urandom_range(32767, 1));
      if (!long_side) w.qty = -w.qty;
      if ($urandom_range(29) == 0) w.qty = 0;
      if ($urandom_range(9) == 0) w.qty = 16'($urandom);
      w.avg = price(); w.lo = price(); w.hi = price();
      return w;
    end
    if (k < 92) begin w.op = OP_STATS; return w; end
    if (k < 95) begin w.op = OP_CLEAR; return w; end
    w.op = op_t'($urandom_range(3));
    w.profit = 40'(rnd64()); w.adverse = 40'(rnd64()); w.qty = 16'($urandom);
    w.avg = 39'(rnd64()); w.lo = 39'(rnd64()); w.hi = 39'(rnd64());
    return w;
  endfunction

  initial begin
    rst = 1; start = 0; cfg_valid = 0; cfg_index = REG_GREEN; cfg_data = 0;
    op = OP_LOAD; trade_profit = 0; trade_adverse = 0; position_qty = 0;
    average_price = 0; bar_low = 0; bar_high = 0;
    idle_pct = 11; long_side = 1; base_price = 39'(65536 * 4000);
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // empty store, skipped loads, saturated magnitude, single entry, markers disabled
    send(mk(OP_STATS, 0, 0, 0, 0, 0, 0));
    send(mk(OP_LOAD, 0, 40'sd100, 0, 0, 0, 0));
    send(mk(OP_LOAD, -40'sd5, 40'sd100, 0, 0, 0, 0));
    send(mk(OP_LOAD, 40'sd5, 0, 0, 0, 0, 0));
    send(mk(OP_LOAD, 40'sh7F_FFFF_FFFF, 40'sh80_0000_0000, 0, 0, 0, 0));
    send(mk(OP_STATS, 0, 0, 0, 0, 0, 0));
    send(mk(OP_LOAD, 40'sd1, -40'sd70000, 0, 0, 0, 0));
    send(mk(OP_LOAD, 40'sd1, 40'sd3, 0, 0, 0, 0));
    send(mk(OP_STATS, 0, 0, 0, 0, 0, 0));
    send(mk(OP_BAR, 0, 0, 16'sd10, 39'd500000, 39'd400000, 39'd600000));
    send(mk(OP_BAR, 0, 0, 0, 39'd500000, 39'd400000, 39'd600000));

    set_all(0, 65536, 55706, 32'hFFFF_FFFF);
    send(mk(OP_STATS, 0, 0, 0, 0, 0, 0));
    send(mk(OP_BAR, 0, 0, 16'sd1, 39'd1000, 39'd900, 39'd1100));
    send(mk(OP_BAR, 0, 0, 16'sd32767, 39'd0, 39'd800, 39'd1100));
    send(mk(OP_BAR, 0, 0, -16'sd32768, 39'h7F_FFFF_FFFF, 39'd0, 39'h7F_FFFF_FFFF));
    send(mk(OP_BAR, 0, 0, -16'sd1, 39'd5, 39'd0, 39'd10));
    send(mk(OP_CLEAR, 0, 0, 0, 0, 0, 0));
    send(mk(OP_STATS, 0, 0, 0, 0, 0, 0));
    for (int i = 0; i < 300; i++) send(rand_word());

    set_all($urandom_range(65536), $urandom_range(65536), $urandom_range(65536), 65536);
    idle_pct = 70;
    // fill the store past its end
    send(mk(OP_CLEAR, 0, 0, 0, 0, 0, 0));
    for (int i = 0; i < MAX_TRADES + 10; i++) begin
      trade_word_t w;
      w = rand_load();
      w.profit = 40'sd1; w.adverse = 40'($urandom_range(65536 * 300, 1));
      send(w);
    end
    send(mk(OP_STATS, 0, 0, 0, 0, 0, 0));
    for (int i = 0; i < 100; i++) send(rand_word());

    set_all(32768, 49152, 65536, $urandom_range(65536 * 40));
    idle_pct = 0;
    for (int i = 0; i < 300; i++) send(rand_word());

    start <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
`default_nettype wire

>>> files.f
rtl/aepm_pkg.sv
rtl/aepm_cell.sv
rtl/aepm_chain.sv
rtl/adverse_excursion_percentile_markers.sv
rtl/aepm_checker.sv
test/tb_adverse_excursion_percentile_markers.sv
